@@ sv/cmsp_pkg.sv @@
// Shared types and constants for the message stream parser.
package cmsp_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned LenW    = 17;
    localparam int unsigned OptNumW = 16;

    localparam logic [ByteW-1:0]   MarkerByte = 8'hff;
    localparam logic [3:0]         NibReserved = 4'd15;
    localparam logic [3:0]         NibExt1     = 4'd13;
    localparam logic [3:0]         NibExt2     = 4'd14;
    localparam logic [3:0]         TokenMax    = 4'd8;
    localparam logic [LenW-1:0]    Ext1Offset  = 17'd13;
    localparam logic [LenW-1:0]    Ext2Offset  = 17'd269;
    localparam logic [OptNumW+1:0] OptNumMax   = 18'd65535;

    typedef enum logic [3:0] {
        PH_H0      = 4'd0,
        PH_H1      = 4'd1,
        PH_H2      = 4'd2,
        PH_H3      = 4'd3,
        PH_TOKEN   = 4'd4,
        PH_OPT     = 4'd5,
        PH_D1      = 4'd6,
        PH_D2      = 4'd7,
        PH_L1      = 4'd8,
        PH_L2      = 4'd9,
        PH_VALUE   = 4'd10,
        PH_PAYLOAD = 4'd11,
        PH_SKIP    = 4'd12
    } phase_t;

    typedef enum logic [2:0] {
        EV_HEADER    = 3'd0,
        EV_TOKEN     = 3'd1,
        EV_OPT_START = 3'd2,
        EV_OPT_VALUE = 3'd3,
        EV_PAYLOAD   = 3'd4,
        EV_ERROR     = 3'd5
    } event_kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_TOKEN_LEN = 3'd1,
        ERR_RESERVED  = 3'd2,
        ERR_TRUNCATED = 3'd3,
        ERR_OVERFLOW  = 3'd4,
        ERR_EMPTY_PAY = 3'd5
    } error_code_t;

    typedef struct packed {
        logic [2:0]         event_kind;
        logic [1:0]         version;
        logic [1:0]         msg_type;
        logic [3:0]         token_length;
        logic [2:0]         code_class;
        logic [4:0]         code_detail;
        logic [15:0]        message_id;
        logic [OptNumW-1:0] option_number;
        logic [LenW-1:0]    option_length;
        logic [ByteW-1:0]   data_byte;
        logic               end_flag;
        logic [2:0]         error_code;
    } result_t;

endpackage

@@ sv/cmsp_if.sv @@
// Request channels: message bytes in, parse events out.
interface cmsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       end_of_msg;

    modport source (output valid, output msg_byte, output end_of_msg, input ready);
    modport sink   (input valid, input msg_byte, input end_of_msg, output ready);
endinterface

interface cmsp_event_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [1:0]  version;
    logic [1:0]  msg_type;
    logic [3:0]  token_length;
    logic [2:0]  code_class;
    logic [4:0]  code_detail;
    logic [15:0] message_id;
    logic [15:0] option_number;
    logic [16:0] option_length;
    logic [7:0]  data_byte;
    logic        end_flag;
    logic [2:0]  error_code;

    modport source (
        output valid, output event_kind, output version, output msg_type,
        output token_length, output code_class, output code_detail,
        output message_id, output option_number, output option_length,
        output data_byte, output end_flag, output error_code, input ready
    );
    modport sink (
        input valid, input event_kind, input version, input msg_type,
        input token_length, input code_class, input code_detail,
        input message_id, input option_number, input option_length,
        input data_byte, input end_flag, input error_code, output ready
    );
endinterface

@@ sv/cmsp_decode.sv @@
// Parse state and per-byte event decode.
module cmsp_decode
    import cmsp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [ByteW-1:0] msg_byte,
    input  logic             end_of_msg,
    output logic             has_result,
    output result_t          result
);

    phase_t             phase_reg, phase_next;
    logic [23:0]        hdr_reg, hdr_next;
    logic [3:0]         tok_left_reg, tok_left_next;
    logic [ByteW-1:0]   head_reg, head_next;
    logic [OptNumW-1:0] opt_sum_reg, opt_sum_next;
    logic [LenW-1:0]    pend_delta_reg, pend_delta_next;
    logic [LenW-1:0]    pend_len_reg, pend_len_next;
    logic [LenW-1:0]    val_left_reg, val_left_next;

    logic               do_after_delta;
    logic               do_finish;
    logic [LenW-1:0]    delta_val;
    logic [LenW-1:0]    len_val;
    logic [3:0]         len_nib;
    logic [LenW-1:0]    delta_use;
    logic [OptNumW+1:0] sum;
    logic [3:0]         tkl;

    always_comb
    begin
        phase_next      = phase_reg;
        hdr_next        = hdr_reg;
        tok_left_next   = tok_left_reg;
        head_next       = head_reg;
        opt_sum_next    = opt_sum_reg;
        pend_delta_next = pend_delta_reg;
        pend_len_next   = pend_len_reg;
        val_left_next   = val_left_reg;
        has_result      = 1'b0;
        result          = '0;
        do_after_delta  = 1'b0;
        do_finish       = 1'b0;
        delta_val       = '0;
        len_val         = '0;
        len_nib         = '0;
        tkl             = hdr_reg[19:16];

        case (phase_reg)
            PH_H0:
            begin
                hdr_next   = {msg_byte, 16'h0000};
                phase_next = PH_H1;
            end
            PH_H1:
            begin
                hdr_next[15:8] = msg_byte;
                phase_next     = PH_H2;
            end
            PH_H2:
            begin
                hdr_next[7:0] = msg_byte;
                phase_next    = PH_H3;
            end
            PH_H3:
            begin
                has_result = 1'b1;
                if (tkl > TokenMax)
                begin
                    result.event_kind = EV_ERROR;
                    result.error_code = ERR_TOKEN_LEN;
                    phase_next        = PH_SKIP;
                end
                else
                begin
                    result.event_kind   = EV_HEADER;
                    result.version      = hdr_reg[23:22];
                    result.msg_type     = hdr_reg[21:20];
                    result.token_length = tkl;
                    result.code_class   = hdr_reg[15:13];
                    result.code_detail  = hdr_reg[12:8];
                    result.message_id   = {hdr_reg[7:0], msg_byte};
                    tok_left_next       = tkl;
                    phase_next          = (tkl != 4'd0) ? PH_TOKEN : PH_OPT;
                end
            end
            PH_TOKEN:
            begin
                has_result        = 1'b1;
                result.event_kind = EV_TOKEN;
                result.data_byte  = msg_byte;
                tok_left_next     = tok_left_reg - 4'd1;
                if (tok_left_next == 4'd0)
                    phase_next = PH_OPT;
            end
            PH_OPT:
            begin
                if (msg_byte == MarkerByte)
                    phase_next = PH_PAYLOAD;
                else if (msg_byte[7:4] == NibReserved || msg_byte[3:0] == NibReserved)
                begin
                    has_result        = 1'b1;
                    result.event_kind = EV_ERROR;
                    result.error_code = ERR_RESERVED;
                    phase_next        = PH_SKIP;
                end
                else
                begin
                    head_next = msg_byte;
                    if (msg_byte[7:4] >= NibExt1)
                        phase_next = PH_D1;
                    else
                    begin
                        delta_val      = {13'd0, msg_byte[7:4]};
                        len_nib        = msg_byte[3:0];
                        do_after_delta = 1'b1;
                    end
                end
            end
            PH_D1:
            begin
                if (head_reg[7:4] == NibExt1)
                begin
                    delta_val      = {9'd0, msg_byte} + Ext1Offset;
                    len_nib        = head_reg[3:0];
                    do_after_delta = 1'b1;
                end
                else
                begin
                    pend_delta_next = {1'b0, msg_byte, 8'h00};
                    phase_next      = PH_D2;
                end
            end
            PH_D2:
            begin
                delta_val      = {1'b0, pend_delta_reg[15:8], msg_byte} + Ext2Offset;
                len_nib        = head_reg[3:0];
                do_after_delta = 1'b1;
            end
            PH_L1:
            begin
                if (head_reg[3:0] == NibExt1)
                begin
                    len_val   = {9'd0, msg_byte} + Ext1Offset;
                    do_finish = 1'b1;
                end
                else
                begin
                    pend_len_next = {1'b0, msg_byte, 8'h00};
                    phase_next    = PH_L2;
                end
            end
            PH_L2:
            begin
                len_val   = {1'b0, pend_len_reg[15:8], msg_byte} + Ext2Offset;
                do_finish = 1'b1;
            end
            PH_VALUE:
            begin
                has_result           = 1'b1;
                result.event_kind    = EV_OPT_VALUE;
                result.option_number = opt_sum_reg;
                result.data_byte     = msg_byte;
                val_left_next        = val_left_reg - 17'd1;
                if (val_left_next == '0)
                    phase_next = PH_OPT;
            end
            PH_PAYLOAD:
            begin
                has_result        = 1'b1;
                result.event_kind = EV_PAYLOAD;
                result.data_byte  = msg_byte;
            end
            default:
            begin
                phase_next = PH_SKIP;
            end
        endcase

        if (do_after_delta)
        begin
            pend_delta_next = delta_val;
            if (len_nib >= NibExt1)
                phase_next = PH_L1;
            else
            begin
                len_val   = {13'd0, len_nib};
                do_finish = 1'b1;
            end
        end

        delta_use = do_after_delta ? delta_val : pend_delta_reg;
        sum       = {2'b00, opt_sum_reg} + {1'b0, delta_use};

        if (do_finish)
        begin
            has_result = 1'b1;
            if (sum > OptNumMax)
            begin
                result.event_kind = EV_ERROR;
                result.error_code = ERR_OVERFLOW;
                phase_next        = PH_SKIP;
            end
            else
            begin
                opt_sum_next         = sum[OptNumW-1:0];
                val_left_next        = len_val;
                result.event_kind    = EV_OPT_START;
                result.option_number = sum[OptNumW-1:0];
                result.option_length = len_val;
                phase_next           = (len_val != '0) ? PH_VALUE : PH_OPT;
            end
        end

        if (end_of_msg)
        begin
            case (phase_next)
                PH_H1, PH_H2, PH_H3, PH_TOKEN, PH_D1, PH_D2, PH_L1, PH_L2, PH_VALUE:
                begin
                    has_result        = 1'b1;
                    result            = '0;
                    result.event_kind = EV_ERROR;
                    result.error_code = ERR_TRUNCATED;
                end
                PH_PAYLOAD:
                begin
                    if (!has_result)
                    begin
                        has_result        = 1'b1;
                        result            = '0;
                        result.event_kind = EV_ERROR;
                        result.error_code = ERR_EMPTY_PAY;
                    end
                end
                default:
                begin
                end
            endcase
            result.end_flag = has_result;
            phase_next      = PH_H0;
            hdr_next        = '0;
            tok_left_next   = '0;
            head_next       = '0;
            opt_sum_next    = '0;
            pend_delta_next = '0;
            pend_len_next   = '0;
            val_left_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_H0;
            hdr_reg        <= '0;
            tok_left_reg   <= '0;
            head_reg       <= '0;
            opt_sum_reg    <= '0;
            pend_delta_reg <= '0;
            pend_len_reg   <= '0;
            val_left_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            hdr_reg        <= hdr_next;
            tok_left_reg   <= tok_left_next;
            head_reg       <= head_next;
            opt_sum_reg    <= opt_sum_next;
            pend_delta_reg <= pend_delta_next;
            pend_len_reg   <= pend_len_next;
            val_left_reg   <= val_left_next;
        end
    end

endmodule

@@ sv/cmsp_out_reg.sv @@
// Result register between the decoder and the event channel.
module cmsp_out_reg
    import cmsp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  logic    load_valid,
    input  result_t load_data,
    input  logic    take,
    output logic    space,
    output logic    valid,
    output result_t data
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign space = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = load_valid;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load && load_valid)
            data_reg <= load_data;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

@@ sv/coap_message_stream_parser_unit.sv @@
// Streaming message parser: one byte per request in, zero or one event out.
// An event appears on the output in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the single result register sets the rate and
// a byte is taken whenever that register is empty or being drained.
// Reset: rst_n clears the parse state to header byte zero and empties the output.
module coap_message_stream_parser_unit
    import cmsp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    cmsp_byte_if.sink    byte_ch,
    cmsp_event_if.source event_ch
);

    logic    accept;
    logic    space;
    logic    has_result;
    logic    out_valid;
    result_t result;
    result_t out_data;

    assign byte_ch.ready = space;
    assign accept        = byte_ch.valid && space;

    cmsp_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .msg_byte   (byte_ch.msg_byte),
        .end_of_msg (byte_ch.end_of_msg),
        .has_result (has_result),
        .result     (result)
    );

    cmsp_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .load_valid (has_result),
        .load_data  (result),
        .take       (event_ch.ready),
        .space      (space),
        .valid      (out_valid),
        .data       (out_data)
    );

    assign event_ch.valid         = out_valid;
    assign event_ch.event_kind    = out_data.event_kind;
    assign event_ch.version       = out_data.version;
    assign event_ch.msg_type      = out_data.msg_type;
    assign event_ch.token_length  = out_data.token_length;
    assign event_ch.code_class    = out_data.code_class;
    assign event_ch.code_detail   = out_data.code_detail;
    assign event_ch.message_id    = out_data.message_id;
    assign event_ch.option_number = out_data.option_number;
    assign event_ch.option_length = out_data.option_length;
    assign event_ch.data_byte     = out_data.data_byte;
    assign event_ch.end_flag      = out_data.end_flag;
    assign event_ch.error_code    = out_data.error_code;

endmodule
